// File: hdl/vdi_pkg.sv
// Shared types and constants for the vertex de-duplication index block.
package vdi_pkg;

    localparam int COORD_W = 64;
    localparam int INDEX_W = 10;

    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic               first;
    } vdi_item_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } vdi_q_ctl_t;

endpackage

// File: hdl/vdi_front.sv
// Input side: mask incoming coordinates and hold them in a two-entry queue.
module vdi_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              coord_width_mode,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [3*vdi_pkg::COORD_W-1:0]     in_data,
    input  logic                              in_first,
    output vdi_pkg::vdi_item_t                q_item,
    output logic                              q_valid,
    input  logic                              q_pop
);
    import vdi_pkg::*;

    vdi_item_t        slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [COORD_W-1:0] mask;
    vdi_item_t        in_item;
    logic             push;
    logic             pop;

    assign mask = coord_width_mode ? {COORD_W{1'b1}} : {{(COORD_W/2){1'b0}}, {(COORD_W/2){1'b1}}};
    assign in_item.x = in_data[COORD_W-1:0] & mask;
    assign in_item.y = in_data[2*COORD_W-1:COORD_W] & mask;
    assign in_item.z = in_data[3*COORD_W-1:2*COORD_W] & mask;
    assign in_item.first = in_first;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: hdl/vdi_search.sv
// Back side: table memory, linear scan for a match, insert and result register.
module vdi_search #(
    parameter int CAPACITY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         coord_width_mode,
    input  vdi_pkg::vdi_item_t           q_item,
    input  vdi_pkg::vdi_q_ctl_t          q_ctl_in,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [vdi_pkg::INDEX_W-1:0]  out_index,
    output logic                         out_is_new,
    output logic                         out_overflow
);
    import vdi_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    logic [3*COORD_W-1:0] mem [CAPACITY];
    logic [3*COORD_W-1:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic [CW-1:0]      cmp_reg, cmp_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [CW-1:0]      res_idx_reg, res_idx_next;
    logic               res_new_reg, res_new_next;
    logic               res_ovf_reg, res_ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_new_reg;
    logic               out_ovf_reg;
    logic               load;
    logic               wr_en;
    logic               hit;
    logic [COORD_W-1:0] mask;
    logic [CW+INDEX_W-1:0] idx_ext;

    assign mask = coord_width_mode ? {COORD_W{1'b1}} : {{(COORD_W/2){1'b0}}, {(COORD_W/2){1'b1}}};
    assign hit  = cmp_valid_reg
                  && ((rd_data_reg[COORD_W-1:0] & mask) == x_reg)
                  && ((rd_data_reg[2*COORD_W-1:COORD_W] & mask) == y_reg)
                  && ((rd_data_reg[3*COORD_W-1:2*COORD_W] & mask) == z_reg);
    assign idx_ext = {{INDEX_W{1'b0}}, res_idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        iss_next       = iss_reg;
        cmp_next       = cmp_reg;
        cmp_valid_next = 1'b0;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load           = 1'b0;
        wr_en          = 1'b0;
        q_pop          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_ctl_in.valid)
                begin
                    q_pop      = 1'b1;
                    load       = 1'b1;
                    n_next     = q_item.first ? '0 : count_reg;
                    iss_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_idx_next = cmp_reg;
                    res_new_next = 1'b0;
                    res_ovf_next = 1'b0;
                    count_next   = n_reg;
                    state_next   = S_DONE;
                end
                else if (iss_reg < n_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_next       = iss_reg;
                    iss_next       = iss_reg + 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    if (n_reg >= CAP_C)
                    begin
                        res_idx_next = '0;
                        res_new_next = 1'b0;
                        res_ovf_next = 1'b1;
                        count_next   = n_reg;
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        res_idx_next = n_reg;
                        res_new_next = 1'b1;
                        res_ovf_next = 1'b0;
                        count_next   = n_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        iss_reg     <= iss_next;
        cmp_reg     <= cmp_next;
        res_idx_reg <= res_idx_next;
        res_new_reg <= res_new_next;
        res_ovf_reg <= res_ovf_next;
        if (load)
        begin
            x_reg <= q_item.x;
            y_reg <= q_item.y;
            z_reg <= q_item.z;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_index_reg <= idx_ext[INDEX_W-1:0];
            out_new_reg   <= res_new_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[n_reg[AW-1:0]] <= {z_reg, y_reg, x_reg};
        end
        else
        begin
            rd_data_reg <= mem[iss_reg[AW-1:0]];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign out_is_new   = out_new_reg;
    assign out_overflow = out_ovf_reg;

endmodule

// File: hdl/vertex_dedup_index.sv
// The search scans the vertices stored in the mesh, reading one table entry per cycle
// from a single-port memory of CAPACITY entries.
// A two-entry input queue accepts beats while a search runs; the result register holds one.
// Reset clears the vertex count, queue and handshake state; the table is not cleared.
// Top level of the vertex de-duplication index block.
module vertex_dedup_index #(
    parameter int CAPACITY = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,          // coord_width_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,       // coord_x, coord_y, coord_z
    input  logic         s_axis_tuser,       // first_of_mesh
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,       // vertex_index, zero pad
    output logic [1:0]   m_axis_tuser        // is_new, overflow
);
    import vdi_pkg::*;

    logic               mode_reg;
    vdi_item_t          q_item;
    vdi_q_ctl_t         q_ctl;
    logic               q_valid;
    logic               q_pop;
    logic [INDEX_W-1:0] idx;
    logic               is_new;
    logic               ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    vdi_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .coord_width_mode (mode_reg),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_data          (s_axis_tdata),
        .in_first         (s_axis_tuser),
        .q_item           (q_item),
        .q_valid          (q_valid),
        .q_pop            (q_pop)
    );

    assign q_ctl.valid = q_valid;
    assign q_ctl.pop   = q_pop;

    vdi_search #(
        .CAPACITY (CAPACITY)
    ) u_search (
        .clk              (clk),
        .rst_n            (rst_n),
        .coord_width_mode (mode_reg),
        .q_item           (q_item),
        .q_ctl_in         (q_ctl),
        .q_pop            (q_pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_index        (idx),
        .out_is_new       (is_new),
        .out_overflow     (ovf)
    );

    assign m_axis_tdata = {{(16-INDEX_W){1'b0}}, idx};
    assign m_axis_tuser = {ovf, is_new};

endmodule

// File: hdl/vdi_checker.sv
// Port-level checker for the vertex de-duplication index block, with its bind.
module vdi_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [15:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("new and overflow both set");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'd0)
        else $error("overflow with nonzero index");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
        else $error("index pad bits set");

endmodule

bind vertex_dedup_index vdi_checker u_vdi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/vertex_dedup_index_tb.sv
// Testbench for vertex_dedup_index: random meshes and a table fill, checked against a predictor.
module vertex_dedup_index_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdi_pkg::*;

    localparam int CAP         = 1024;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int RAND_ITEMS  = 540;

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic               is_new;
        logic               ovf;
    } dedup_res_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;    // coord_x, coord_y, coord_z
    logic         s_axis_tuser;    // first_of_mesh
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;    // vertex_index, zero pad
    logic [1:0]   m_axis_tuser;    // is_new, overflow

    vdi_item_t    vtx_q[$];
    dedup_res_t   index_q[$];
    vdi_item_t    beat_item;
    vdi_item_t    pool[$];

    logic [63:0]  tab_x[CAP];
    logic [63:0]  tab_y[CAP];
    logic [63:0]  tab_z[CAP];
    int           vtx_count;
    logic         wide_mode;

    int           src_idle;
    int           snk_idle;
    int           errors;
    int           cycles;

    vertex_dedup_index #(.CAPACITY(CAP)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic dedup_res_t lookup_vertex(vdi_item_t it);
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        dedup_res_t  r;
        bit          found;
        m = wide_mode ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        x = it.x & m;
        y = it.y & m;
        z = it.z & m;
        found = 1'b0;
        r.idx = '0;
        r.is_new = 1'b0;
        r.ovf = 1'b0;
        if (it.first)
            vtx_count = 0;
        for (int i = 0; i < vtx_count; i++)
        begin
            if (!found && (tab_x[i] & m) == x && (tab_y[i] & m) == y && (tab_z[i] & m) == z)
            begin
                found = 1'b1;
                r.idx = i[INDEX_W-1:0];
            end
        end
        if (!found)
        begin
            if (vtx_count >= CAP)
                r.ovf = 1'b1;
            else
            begin
                tab_x[vtx_count] = x;
                tab_y[vtx_count] = y;
                tab_z[vtx_count] = z;
                r.idx = vtx_count[INDEX_W-1:0];
                r.is_new = 1'b1;
                vtx_count++;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return {32'h0, $urandom};
            3: return {$urandom, 32'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // driver: present pending beats and predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                index_q = {index_q, lookup_vertex(beat_item)};
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (vtx_q.size() > 0 && $urandom_range(0, 99) >= src_idle)
                begin
                    beat_item = vtx_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {beat_item.z, beat_item.y, beat_item.x};
                    s_axis_tuser  <= beat_item.first;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure and result check
    always @(posedge clk or negedge rst_n)
    begin
        dedup_res_t exp_r;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (index_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: index %0d", m_axis_tdata[INDEX_W-1:0]);
                end
                else
                begin
                    exp_r = index_q.pop_front();
                    if (m_axis_tdata[INDEX_W-1:0] !== exp_r.idx || m_axis_tuser[0] !== exp_r.is_new
                        || m_axis_tuser[1] !== exp_r.ovf)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp idx %0d new %0b ovf %0b, got idx %0d new %0b ovf %0b",
                                     exp_r.idx, exp_r.is_new, exp_r.ovf,
                                     m_axis_tdata[INDEX_W-1:0], m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (vtx_q.size() > 0 || index_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        wide_mode = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_vertex(logic first, logic [63:0] x, logic [63:0] y, logic [63:0] z);
        vdi_item_t it;
        it.first = first;
        it.x = x;
        it.y = y;
        it.z = z;
        vtx_q = {vtx_q, it};
    endtask

    task automatic random_meshes(int count);
        vdi_item_t it;
        int        len;
        int        sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) == 0)
                write_mode(1'($urandom_range(0, 1)));
            len = $urandom_range(1, 40);
            pool.delete();
            for (int k = 0; k < len; k++)
            begin
                it.first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                if (pool.size() > 0 && $urandom_range(0, 99) < 55)
                begin
                    it = pool[$urandom_range(0, pool.size() - 1)];
                    it.first = (k == 0);
                    if ($urandom_range(0, 3) == 0)
                        it.x[63:32] = $urandom;
                    if ($urandom_range(0, 3) == 0)
                        it.z[63:32] = $urandom;
                end
                else
                begin
                    it.x = rand_coord();
                    it.y = rand_coord();
                    it.z = rand_coord();
                    pool = {pool, it};
                end
                vtx_q = {vtx_q, it};
                sent++;
            end
        end
    endtask

    initial
    begin
        errors        = 0;
        cycles        = 0;
        vtx_count     = 0;
        wide_mode     = 1'b0;
        src_idle      = 32;
        snk_idle      = 53;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // narrow compare: upper bits ignored
        add_vertex(1'b1, 64'h0, 64'h0, 64'h0);
        add_vertex(1'b0, '1, '1, '1);
        add_vertex(1'b0, 64'h0, 64'h0, 64'h0);
        add_vertex(1'b0, 64'h1234_5678_0000_0000, 64'h0, 64'hFFFF_FFFF_0000_0000);
        add_vertex(1'b0, 64'h0000_0000_FFFF_FFFF, '1, 64'h5555_5555_FFFF_FFFF);
        add_vertex(1'b0, 64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA, 64'h1);
        write_mode(1'b1);
        // wide compare mid-mesh: narrow entries hit, upper-bit variants miss
        add_vertex(1'b0, 64'h5555_5555_AAAA_AAAA, 64'h5555_5555_AAAA_AAAA, 64'h1);
        add_vertex(1'b0, 64'h0, 64'h0, 64'h0);
        add_vertex(1'b0, '1, '1, '1);
        add_vertex(1'b0, '1, '1, '1);
        add_vertex(1'b0, 64'hFFFF_FFFF_0000_0000, 64'h0, 64'h0);
        write_mode(1'b0);
        // several entries now alias; lowest index wins
        add_vertex(1'b0, '1, '1, '1);
        add_vertex(1'b0, 64'h0, 64'h0, 64'h0);
        add_vertex(1'b1, '1, '1, '1);
        add_vertex(1'b0, '1, '1, '1);
        write_mode(1'b1);

        // fill the table past capacity, then hit an existing entry
        for (int i = 0; i < CAP + 6; i++)
            add_vertex(i == 0, {32'(i), 32'(~i)}, 64'(i) << 20, {32'hDEAD_0000 | 32'(i), 32'(i)});
        add_vertex(1'b0, {32'(5), 32'(~5)}, 64'(5) << 20, {32'hDEAD_0005, 32'(5)});
        add_vertex(1'b0, 64'h0, 64'h0, 64'h0);
        add_vertex(1'b0, {32'(CAP - 1), 32'(~(CAP - 1))}, 64'(CAP - 1) << 20,
                   {32'hDEAD_0000 | 32'(CAP - 1), 32'(CAP - 1)});

        random_meshes(RAND_ITEMS / 3);
        wait_idle();
        src_idle = 53;
        snk_idle = 32;
        random_meshes(RAND_ITEMS / 3);
        wait_idle();
        src_idle = 0;
        snk_idle = 0;
        random_meshes(RAND_ITEMS / 3);
        wait_idle();
        repeat (50) @(posedge clk);

        if (errors == 0 && index_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
